// File: rtl/assert_macros.svh
// Assertion helpers used by the receiver core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define CHK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/pffr_pkg.sv
`default_nettype none

package pffr_pkg;

   // Phase codes
   localparam logic [1:0] PH_HUNT  = 2'd0;
   localparam logic [1:0] PH_FLAG  = 2'd1;
   localparam logic [1:0] PH_DATA  = 2'd2;
   localparam logic [1:0] PH_SPARE = 2'd3;  // unused code

   // Result kinds
   localparam logic KIND_SYNC = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // Register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLAG      = 2'd1;

   // Register reset values
   localparam logic [7:0] THRESHOLD_RESET = 8'd56;
   localparam logic [7:0] FLAG_RESET      = 8'h7E;

   localparam logic [3:0]  BYTE_BITS = 4'd8;
   localparam logic [7:0]  COUNT_MAX = 8'hFF;
   localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  phase;
      logic        previous_bit;
      logic [7:0]  preamble_count;
      logic [7:0]  shift_byte;
      logic [3:0]  bits_in_byte;
      logic [15:0] total_bits;
   } state_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  data_byte;
      logic        end_of_frame;
      logic [15:0] bit_count;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_HUNT,
      previous_bit:   1'b1,
      preamble_count: 8'd0,
      shift_byte:     8'd0,
      bits_in_byte:   4'd0,
      total_bits:     16'd0
   };

endpackage

`default_nettype wire

// File: rtl/pffr_step.sv
`default_nettype none

// Next-state and result logic for one received bit.
module pffr_step (
   input  wire  pffr_pkg::state_type  state,
   input  wire                        rx_bit,
   input  wire  [7:0]                 threshold,
   input  wire  [7:0]                 flag,
   output pffr_pkg::state_type        state_next,
   output logic                       emit,
   output pffr_pkg::result_type       result
);

   pffr_pkg::state_type cur;
   logic [8:0]  count_sum;
   logic [7:0]  count_next;
   logic [7:0]  shifted;
   logic [3:0]  bits_next;
   logic [15:0] total_next;

   always_comb begin
      // unused phase code behaves as reset
      cur = (state.phase == pffr_pkg::PH_SPARE) ? pffr_pkg::STATE_RESET : state;

      count_sum  = {1'b0, cur.preamble_count} + 9'd2;
      shifted    = {cur.shift_byte[6:0], rx_bit};
      bits_next  = cur.bits_in_byte + 4'd1;
      total_next = (cur.total_bits == pffr_pkg::TOTAL_MAX) ? cur.total_bits
                                                           : cur.total_bits + 16'd1;
      count_next = cur.preamble_count;

      state_next          = cur;
      emit                = 1'b0;
      result.result_kind  = pffr_pkg::KIND_SYNC;
      result.data_byte    = flag;
      result.end_of_frame = 1'b0;
      result.bit_count    = cur.total_bits;

      unique case (cur.phase)
         pffr_pkg::PH_HUNT: begin
            if (!cur.previous_bit && rx_bit) begin
               count_next = count_sum[8] ? pffr_pkg::COUNT_MAX : count_sum[7:0];
            end else if (cur.previous_bit == rx_bit) begin
               count_next = 8'd0;
            end
            state_next.preamble_count = count_next;
            state_next.previous_bit   = rx_bit;
            if (count_next >= threshold) begin
               state_next.phase        = pffr_pkg::PH_FLAG;
               state_next.total_bits   = {8'd0, count_next};
               state_next.shift_byte   = 8'd0;
               state_next.bits_in_byte = 4'd0;
            end
         end
         pffr_pkg::PH_FLAG: begin
            state_next.shift_byte = shifted;
            if (cur.bits_in_byte < pffr_pkg::BYTE_BITS) begin
               state_next.bits_in_byte = bits_next;
            end
            if (state_next.bits_in_byte >= pffr_pkg::BYTE_BITS && shifted == flag) begin
               emit                    = 1'b1;
               state_next.phase        = pffr_pkg::PH_DATA;
               state_next.shift_byte   = 8'd0;
               state_next.bits_in_byte = 4'd0;
            end
         end
         default: begin
            // data phase
            state_next.shift_byte   = shifted;
            state_next.total_bits   = total_next;
            state_next.bits_in_byte = bits_next;
            if (bits_next >= pffr_pkg::BYTE_BITS) begin
               emit                    = 1'b1;
               result.result_kind      = pffr_pkg::KIND_DATA;
               result.data_byte        = shifted;
               result.end_of_frame     = (shifted == flag);
               result.bit_count        = total_next;
               state_next.shift_byte   = 8'd0;
               state_next.bits_in_byte = 4'd0;
               if (shifted == flag) begin
                  state_next = pffr_pkg::STATE_RESET;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/preamble_flag_frame_receiver_core.sv
`default_nettype none
// A result word is registered: it appears on rsp_ in the cycle after the bit that completes it.
// Throughput: one bit per cycle; the only limit is the single result register,
// which stalls req_ only while it holds a word and rsp_stall is high.
// Reset (synchronous, active high): hunting for preamble, previous bit one, all
// counters and the shift byte cleared, threshold 56, flag 0x7E, no result pending.

`include "assert_macros.svh"

module preamble_flag_frame_receiver_core (
   input  wire          clock,
   input  wire          reset,
   // bit input channel
   input  wire          req_valid,
   output logic         req_stall,
   input  wire          req_rx_bit,
   // result channel
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic         rsp_result_kind,
   output logic [7:0]   rsp_data_byte,
   output logic         rsp_end_of_frame,
   output logic [15:0]  rsp_bit_count,
   // register writes
   input  wire          csr_write,
   input  wire  [pffr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [7:0]   csr_data
);

   // Configuration registers
   logic [7:0] threshold_ff, threshold_in;
   logic [7:0] flag_ff, flag_in;

   // Receiver state
   pffr_pkg::state_type  state_ff, state_in, state_step;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pffr_pkg::result_type result_ff, result_in, result_step;

   logic step_emit;
   logic req_accept;
   logic out_free;

   // Check terms
   logic sync_out;
   logic eof_step;
   logic hunt_clear;

   // Output register drains this cycle or is empty: a new word may land.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !out_free;
   assign req_accept = req_valid && !req_stall;

   pffr_step u_step (
      .state      (state_ff),
      .rx_bit     (req_rx_bit),
      .threshold  (threshold_ff),
      .flag       (flag_ff),
      .state_next (state_step),
      .emit       (step_emit),
      .result     (result_step)
   );

   // Register writes; unknown indexes are dropped.
   always_comb begin
      threshold_in = threshold_ff;
      flag_in      = flag_ff;
      if (csr_write) begin
         if (csr_index == pffr_pkg::REG_THRESHOLD) begin
            threshold_in = csr_data;
         end else if (csr_index == pffr_pkg::REG_FLAG) begin
            flag_in = csr_data;
         end
      end
   end

   // State advances on every accepted bit; result word loads when one is made.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      result_in    = result_ff;
      if (req_accept) begin
         state_in = state_step;
         if (step_emit) begin
            rsp_valid_in = 1'b1;
            result_in    = result_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= pffr_pkg::THRESHOLD_RESET;
         flag_ff      <= pffr_pkg::FLAG_RESET;
         state_ff     <= pffr_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         flag_ff      <= flag_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = result_ff.result_kind;
   assign rsp_data_byte    = result_ff.data_byte;
   assign rsp_end_of_frame = result_ff.end_of_frame;
   assign rsp_bit_count    = result_ff.bit_count;

   assign sync_out   = rsp_valid && rsp_result_kind == pffr_pkg::KIND_SYNC;
   assign eof_step   = req_accept && step_emit && result_step.end_of_frame;
   assign hunt_clear = state_ff.phase == pffr_pkg::PH_HUNT && state_ff.total_bits == 16'd0;

   // A sync word never closes a frame.
   `CHK_ASSERT(a_sync_no_eof, sync_out |-> !rsp_end_of_frame, "sync word flagged end of frame")

   // End of frame drops back to hunting with counters cleared.
   `CHK_ASSERT(a_eof_rehunt, eof_step |=> hunt_clear, "no return to hunt after end of frame")

   // Byte assembly never runs past eight bits.
   `CHK_ASSERT(a_bits_bound, state_ff.bits_in_byte <= pffr_pkg::BYTE_BITS, "byte count overran")

endmodule

`default_nettype wire
